// File: hdl/tcw_pkg.sv
package tcw_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic [7:0] ATTR_RESET = 8'h02;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_word;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } t_out_word;

    typedef enum logic [9:0] {
        S_FILL   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_EXEC   = 10'b0000000100,
        S_BS_RD  = 10'b0000001000,
        S_BS_WR  = 10'b0000010000,
        S_RD_ADR = 10'b0000100000,
        S_RD_DAT = 10'b0001000000,
        S_SCR_RD = 10'b0010000000,
        S_SCR_WR = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

endpackage

// File: hdl/text_console_writer.sv
// Plain characters, CR, tab, line feed, backspace at column zero, out-of-range reads and
// unused ops finish in S_EXEC; backspace also passes S_BS_RD and S_BS_WR, reads S_RD_ADR
// and S_RD_DAT, a clear S_FILL, and a scroll S_SCR_RD and S_SCR_WR, then S_FILL. One word
// is in work at a time: the next is taken only once the last result is loaded for output.
// Reset homes the cursor, sets the attribute to 0x02 and then clears the RAM,
// during which input words are stalled.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS      = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int CELL_COUNT = ROWS * COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLS);
    localparam int TAB_W      = $clog2(TAB_WIDTH);
    localparam int SUM_W      = $clog2(COLS + TAB_WIDTH + 1);
    localparam int LAST_BASE  = (ROWS - 1) * COLS;

    t_state             r_state, n_state;
    t_in_word           r_item, n_item;
    logic [COL_W-1:0]   r_col, n_col;
    logic [TAB_W-1:0]   r_tab, n_tab;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic               r_boot, n_boot;
    logic [7:0]         r_attr;
    logic [7:0]         r_rd_char, n_rd_char;
    logic [7:0]         r_rd_attr, n_rd_attr;
    logic               r_out_valid;
    t_out_word          r_out_data;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [15:0]        w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [15:0]        w_rdata;
    logic [ADDR_W-1:0]  w_cur;
    logic [SUM_W-1:0]   w_tab_col;
    logic               w_load;
    logic               w_accept;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cur     = r_base + ADDR_W'(r_col);
    assign w_tab_col = SUM_W'(r_col) + SUM_W'(TAB_WIDTH) - SUM_W'(r_tab);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_col     = r_col;
        n_tab     = r_tab;
        n_base    = r_base;
        n_ptr     = r_ptr;
        n_boot    = r_boot;
        n_rd_char = r_rd_char;
        n_rd_attr = r_rd_attr;
        w_we      = 1'b0;
        w_waddr   = r_ptr;
        w_wdata   = 16'h0000;
        w_raddr   = w_cur;

        unique case (r_state)
            S_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_DONE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_item  = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rd_char = 8'h00;
                n_rd_attr = 8'h00;
                n_state   = S_DONE;
                unique case (r_item.op)
                    OP_PUT: begin
                        if (r_item.char_code == CH_BS) begin
                            if (r_col != '0) begin
                                n_col   = r_col - 1'b1;
                                n_tab   = (r_tab == '0) ? TAB_W'(TAB_WIDTH - 1)
                                                        : r_tab - 1'b1;
                                n_state = S_BS_RD;
                            end
                        end else if (r_item.char_code == CH_CR) begin
                            n_col = '0;
                            n_tab = '0;
                        end else begin
                            logic wrap;
                            wrap = 1'b0;
                            if (r_item.char_code == CH_LF) begin
                                wrap = 1'b1;
                            end else if (r_item.char_code == CH_TAB) begin
                                n_tab = '0;
                                if (w_tab_col >= SUM_W'(COLS)) begin
                                    wrap = 1'b1;
                                end else begin
                                    n_col = COL_W'(w_tab_col);
                                end
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_cur;
                                w_wdata = {r_attr, r_item.char_code};
                                n_tab   = (r_tab == TAB_W'(TAB_WIDTH - 1)) ? '0
                                                                           : r_tab + 1'b1;
                                if (r_col == COL_W'(COLS - 1)) begin
                                    wrap = 1'b1;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                            if (wrap) begin
                                n_col = '0;
                                n_tab = '0;
                                if (r_base == ADDR_W'(LAST_BASE)) begin
                                    n_ptr   = '0;
                                    n_state = S_SCR_RD;
                                end else begin
                                    n_base = r_base + ADDR_W'(COLS);
                                end
                            end
                        end
                    end
                    OP_READ: begin
                        if (32'(r_item.cell_index) < 32'(CELL_COUNT)) begin
                            n_state = S_RD_ADR;
                        end
                    end
                    OP_CLEAR: begin
                        n_col   = '0;
                        n_tab   = '0;
                        n_base  = '0;
                        n_ptr   = '0;
                        n_state = S_FILL;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_BS_RD: begin
                w_raddr = w_cur;
                n_state = S_BS_WR;
            end
            S_BS_WR: begin
                w_we    = 1'b1;
                w_waddr = w_cur;
                w_wdata = {w_rdata[15:8], 8'h00};
                n_state = S_DONE;
            end
            S_RD_ADR: begin
                w_raddr = ADDR_W'(r_item.cell_index);
                n_state = S_RD_DAT;
            end
            S_RD_DAT: begin
                n_rd_char = w_rdata[7:0];
                n_rd_attr = w_rdata[15:8];
                n_state   = S_DONE;
            end
            S_SCR_RD: begin
                w_raddr = r_ptr + ADDR_W'(COLS);
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = w_rdata;
                n_ptr   = r_ptr + 1'b1;
                n_state = (r_ptr == ADDR_W'(LAST_BASE - 1)) ? S_FILL : S_SCR_RD;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_col       <= '0;
            r_tab       <= '0;
            r_base      <= '0;
            r_ptr       <= '0;
            r_boot      <= 1'b1;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_tab   <= n_tab;
            r_base  <= n_base;
            r_ptr   <= n_ptr;
            r_boot  <= n_boot;
            if (i_cfg_valid && o_cfg_ready) begin
                r_attr <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_rd_char <= n_rd_char;
        r_rd_attr <= n_rd_attr;
        if (w_load) begin
            r_out_data.cursor_pos <= 11'(w_cur);
            r_out_data.cell_char  <= r_rd_char;
            r_out_data.cell_attr  <= r_rd_attr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hdl/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
